FILE: rtl/ssg_pkg.sv
// Shared types, constants and tables of the sinusoid sample generator.
package ssg_pkg;

  localparam int DIV_STEPS         = 22;  // bits of i*limit
  localparam int RED_STEPS         = 10;  // multiples 2pi<<9 .. 2pi<<0
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CNT_W             = 5;

  localparam logic signed [45:0] Q30_TWO_PI  = 46'sd6746518852;
  localparam logic signed [45:0] Q30_PI      = 46'sd3373259426;
  localparam logic signed [45:0] Q30_HALF_PI = 46'sd1686629713;
  localparam logic signed [45:0] Q30_TWO_PI_RED = 46'sd3454217652224; // 2pi << 9
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [49:0] Q30_HALF    = 50'sd536870912;

  typedef enum logic [2:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_FREQUENCY  = 3'd1,
    REG_PHASE      = 3'd2,
    REG_USE_COSINE = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             load_req;
    logic             ld_prod;
    logic             div_step;
    logic             ld_theta;
    logic             red_init;
    logic             red_step;
    logic             wrap;
    logic             fold;
    logic             rot_step;
    logic             scale;
    logic             emit;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

  // Q.30 arctangent of 2^-i
  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] idx);
    logic [29:0] a;
    unique case (idx)
      5'd0:  a = 30'd843314857;
      5'd1:  a = 30'd497837830;
      5'd2:  a = 30'd263043837;
      5'd3:  a = 30'd133525159;
      5'd4:  a = 30'd67021687;
      5'd5:  a = 30'd33543516;
      5'd6:  a = 30'd16775851;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194283;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048576;
      5'd11: a = 30'd524288;
      5'd12: a = 30'd262144;
      5'd13: a = 30'd131072;
      5'd14: a = 30'd65536;
      5'd15: a = 30'd32768;
      5'd16: a = 30'd16384;
      5'd17: a = 30'd8192;
      5'd18: a = 30'd4096;
      5'd19: a = 30'd2048;
      5'd20: a = 30'd1024;
      5'd21: a = 30'd512;
      5'd22: a = 30'd256;
      5'd23: a = 30'd128;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/ssg_if.sv
// Handshake channel interfaces: sweep request, point result, register write.
interface ssg_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] horizontal_limit;
  logic [5:0]  point_count;
  modport source (output valid, horizontal_limit, point_count, input ready);
  modport sink   (input valid, horizontal_limit, point_count, output ready);
endinterface

interface ssg_pt_if;
  logic               valid;
  logic               ready;
  logic        [15:0] x_value;
  logic signed [15:0] y_value;
  logic               last_point;
  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

interface ssg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ssg_ctrl.sv
// Sequencer: walks each point through divide, reduce, rotate, scale, emit.
module ssg_ctrl import ssg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_PROD  = 11'b000_0000_0010,
    S_DIV   = 11'b000_0000_0100,
    S_THETA = 11'b000_0000_1000,
    S_RINIT = 11'b000_0001_0000,
    S_RED   = 11'b000_0010_0000,
    S_WRAP  = 11'b000_0100_0000,
    S_FOLD  = 11'b000_1000_0000,
    S_ROT   = 11'b001_0000_0000,
    S_SCALE = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.cnt   = cnt_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.ld_prod = 1'b1;
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_THETA;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_THETA: begin
        cmd_o.ld_theta = 1'b1;
        state_d        = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.red_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_RED;
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        if (cnt_q == CNT_W'(RED_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_WRAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        cnt_d      = '0;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          cnt_d   = '0;
          state_d = S_SCALE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? S_IDLE : S_PROD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/ssg_dp.sv
// Datapath: registers, divider, angle reduction, CORDIC, scaling, output register.
module ssg_dp import ssg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic        [15:0] horizontal_limit_i,
  input  logic        [5:0]  point_count_i,
  input  logic               cfg_valid_i,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  output logic               pt_valid_o,
  input  logic               pt_ready_i,
  output logic        [15:0] x_value_o,
  output logic signed [15:0] y_value_o,
  output logic               last_point_o
);

  logic signed [15:0] amp_q, freq_q, phase_q;
  logic               cos_q;

  logic [15:0]        limit_q;
  logic [5:0]         n_q, i_q;
  logic [21:0]        dvd_q;
  logic [5:0]         rem_q;
  logic [15:0]        x_q;
  logic signed [45:0] theta_q, r_q;
  logic signed [33:0] cx_q, cy_q, z_q;
  logic signed [49:0] yprod_q;
  logic               out_valid_q;

  logic [6:0]         trial;
  logic [15:0]        x_w;
  logic signed [32:0] fx;
  logic signed [45:0] theta_w, red_sub;
  logic [CNT_W-1:0]   red_k;
  logic signed [33:0] shx, shy, atan_w;
  logic signed [49:0] yround, yshift;
  logic signed [15:0] ysat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q   <= 16'sd256;
      freq_q  <= 16'sd4096;
      phase_q <= 16'sd0;
      cos_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AMPLITUDE:  amp_q   <= cfg_data_i;
        REG_FREQUENCY:  freq_q  <= cfg_data_i;
        REG_PHASE:      phase_q <= cfg_data_i;
        REG_USE_COSINE: cos_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign trial   = {rem_q, dvd_q[21]} - {1'b0, n_q};
  assign x_w     = (n_q == 6'd0) ? 16'd0 : dvd_q[15:0];
  assign fx      = freq_q * $signed({1'b0, x_w});
  assign theta_w = (46'(fx) <<< 10) + (46'(phase_q) <<< 18)
                 + (cos_q ? Q30_HALF_PI : 46'sd0);
  assign red_k   = CNT_W'(RED_STEPS - 1) - cmd_i.cnt;
  assign red_sub = Q30_TWO_PI <<< red_k;
  assign shx     = cx_q >>> cmd_i.cnt;
  assign shy     = cy_q >>> cmd_i.cnt;
  assign atan_w  = $signed({4'b0000, atan_q30(cmd_i.cnt)});
  assign yround  = yprod_q + Q30_HALF;
  assign yshift  = yround >>> 30;

  always_comb begin
    if (yshift > 50'sd32767)       ysat = 16'sh7fff;
    else if (yshift < -50'sd32768) ysat = 16'sh8000;
    else                           ysat = yshift[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      limit_q <= horizontal_limit_i;
      n_q     <= point_count_i;
      i_q     <= '0;
    end
    if (cmd_i.ld_prod) begin
      dvd_q <= 22'(i_q) * 22'(limit_q);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      // restoring step: quotient bits shift in from the right
      if (!trial[6]) rem_q <= trial[5:0];
      else           rem_q <= {rem_q[4:0], dvd_q[21]};
      dvd_q <= {dvd_q[20:0], ~trial[6]};
    end
    if (cmd_i.ld_theta) begin
      x_q     <= x_w;
      theta_q <= theta_w;
    end
    // a large multiple of 2pi makes a negative angle positive
    if (cmd_i.red_init) r_q <= theta_q[45] ? theta_q + Q30_TWO_PI_RED : theta_q;
    if (cmd_i.red_step && (r_q >= red_sub)) r_q <= r_q - red_sub;
    if (cmd_i.wrap && (r_q > Q30_PI)) r_q <= r_q - Q30_TWO_PI;
    if (cmd_i.fold) begin
      if (r_q > Q30_HALF_PI)       z_q <= 34'(Q30_PI - r_q);
      else if (r_q < -Q30_HALF_PI) z_q <= 34'(-Q30_PI - r_q);
      else                         z_q <= 34'(r_q);
      cx_q <= Q30_GAIN;
      cy_q <= '0;
    end
    if (cmd_i.rot_step) begin
      if (!z_q[33]) begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        z_q  <= z_q - atan_w;
      end else begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        z_q  <= z_q + atan_w;
      end
    end
    if (cmd_i.scale) yprod_q <= amp_q * cy_q;
    if (cmd_i.emit) begin
      x_value_o    <= x_q;
      y_value_o    <= ysat;
      last_point_o <= (i_q == n_q);
      i_q          <= i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (pt_ready_i) out_valid_q <= 1'b0;
  end

  assign pt_valid_o     = out_valid_q;
  assign sts_o.out_free = !out_valid_q || pt_ready_i;
  assign sts_o.last     = (i_q == n_q);

endmodule

FILE: rtl/sinusoid_sample_generator.sv
// Top level of the sinusoid sample generator.
// A request (horizontal_limit L, point_count N) yields N+1 points x_i = floor(i*L/N),
// y_i = amplitude*sin(frequency*x_i + phase) (cos when use_cosine is set), Q8.8,
// with y saturated. Requests are taken one at a time. Each point passes in turn
// through the product i*L, the bit-serial x divider, the angle sum, the 2*pi
// reduction subtractor, the wrap and fold, the CORDIC rotation, the amplitude
// product and output, where a point waits while the output register is full. The
// next request is accepted while the last point still waits in the output
// register. Registers may be written whenever the block is idle.
module sinusoid_sample_generator import ssg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  ssg_req_if.sink   req_i,
  ssg_pt_if.source  pt_o,
  ssg_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  ssg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .horizontal_limit_i (req_i.horizontal_limit),
    .point_count_i      (req_i.point_count),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .pt_valid_o         (pt_o.valid),
    .pt_ready_i         (pt_o.ready),
    .x_value_o          (pt_o.x_value),
    .y_value_o          (pt_o.y_value),
    .last_point_o       (pt_o.last_point)
  );

endmodule
